// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
    logic desc;
  } ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell #(
  parameter int W   = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  spq_pkg::ctrl_t      ctrl,
  input  logic [CW-1:0]       count,
  input  logic signed [W-1:0] ins_value,
  input  logic signed [W-1:0] left_value,
  input  logic                left_ge,
  input  logic signed [W-1:0] right_value,
  output logic signed [W-1:0] value,
  output logic                ge
);

  logic signed [W-1:0] value_r;
  logic signed [W-1:0] value_nxt;
  logic                occ;
  logic                lt;

  // A cell flags ge when the new word belongs at it or at an earlier cell. The
  // flag is carried down the chain, so the first flagged cell takes the new
  // word and every later cell shifts, whatever order the stored words are in.
  assign occ   = CW'(IDX) < count;
  assign lt    = value_r < ins_value;
  assign ge    = left_ge || !occ || (ctrl.desc ? lt : !lt);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (ge && left_ge) begin
        value_nxt = left_value;
      end else if (ge) begin
        value_nxt = ins_value;
      end
    end else if (ctrl.rem) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_wr_en              cfg_wr_data (descending order)
// in       in         in_valid / in_ready    in_command, in_value
// out      out        out_valid / out_ready  head, valid flag, count, removed, status
//
// Every cell compares the broadcast value at once and shifts in the same edge,
// so a new word is taken every cycle unless the output register holds it off.
// The result sits in an output register; a new word is taken while it waits
// only if it is being read in the same cycle.
// Reset empties the list and clears the order setting; no clearing pass.
module sorted_priority_queue #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_head_value,
  output logic               out_head_valid,
  output logic [4:0]         out_entry_count,
  output logic signed [31:0] out_removed_value,
  output logic [1:0]         out_status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                          desc_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic                          out_valid_r;
  logic signed [31:0]            head_value_r;
  logic                          head_valid_r;
  logic [4:0]                    entry_count_r;
  logic signed [31:0]            removed_value_r;
  spq_pkg::status_t              status_r;
  spq_pkg::status_t              status_nxt;

  logic                          accept;
  logic                          full;
  logic                          empty;
  spq_pkg::ctrl_t                ctrl;
  logic signed [VALUE_WIDTH-1:0] ins_value;
  logic signed [VALUE_WIDTH-1:0] head_nxt;
  logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic                          cell_ge    [DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = count_r == CW'(DEPTH);
  assign empty     = count_r == '0;
  assign ins_value = VALUE_WIDTH'($unsigned(in_value));

  always_comb begin
    ctrl.desc  = desc_r;
    ctrl.ins   = accept && (in_command == spq_pkg::CMD_INSERT) && !full;
    ctrl.rem   = accept && (in_command == spq_pkg::CMD_REMOVE) && !empty;
    status_nxt = spq_pkg::ST_DONE;
    if (in_command == spq_pkg::CMD_INSERT && full) begin
      status_nxt = spq_pkg::ST_FULL;
    end else if (in_command == spq_pkg::CMD_REMOVE && empty) begin
      status_nxt = spq_pkg::ST_EMPTY;
    end
    count_nxt = count_r;
    head_nxt  = cell_value[0];
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
      if (cell_ge[0]) begin
        head_nxt = ins_value;
      end
    end else if (ctrl.rem) begin
      count_nxt = count_r - CW'(1);
      head_nxt  = cell_value[1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_ge;
    logic signed [VALUE_WIDTH-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = ins_value;
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[g-1];
      assign left_ge    = cell_ge[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_value = cell_value[g];
    end else begin : g_inner
      assign right_value = cell_value[g+1];
    end

    spq_cell #(
      .W   (VALUE_WIDTH),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .ins_value   (ins_value),
      .left_value  (left_value),
      .left_ge     (left_ge),
      .right_value (right_value),
      .value       (cell_value[g]),
      .ge          (cell_ge[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        desc_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_value_r    <= (count_nxt != '0) ? 32'(head_nxt) : '0;
      head_valid_r    <= count_nxt != '0;
      entry_count_r   <= 5'(count_nxt);
      removed_value_r <= ctrl.rem ? 32'(cell_value[0]) : '0;
      status_r        <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_value    = head_value_r;
  assign out_head_valid    = head_valid_r;
  assign out_entry_count   = entry_count_r;
  assign out_removed_value = removed_value_r;
  assign out_status        = status_r;

endmodule

// ----- rtl/spq_checker.sv -----
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_head_value,
  input logic               out_head_valid,
  input logic [4:0]         out_entry_count,
  input logic signed [31:0] out_removed_value,
  input logic [1:0]         out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head_value)
      && $stable(out_status) && $stable(out_entry_count))
    else $error("result word changed while stalled");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_head_value == '0 && out_entry_count == '0)
    else $error("empty list reports a head or a count");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_EMPTY |->
      out_entry_count == '0 && out_removed_value == '0 && !out_head_valid)
    else $error("remove on empty list reports data");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_head_value    (out_head_value),
  .out_head_valid    (out_head_valid),
  .out_entry_count   (out_entry_count),
  .out_removed_value (out_removed_value),
  .out_status        (out_status)
);

// ----- tb/tb_sorted_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

  localparam int QUEUE_DEPTH = 16;
  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam int SCRIPT_ROWS = 25;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         entry_count;
    logic signed [31:0] removed_value;
    spq_pkg::status_t   status;
  } report_t;

  typedef struct packed {
    logic               desc;
    logic               cmd;
    logic signed [31:0] value;
    logic               typed;
    report_t            want;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_command = spq_pkg::CMD_INSERT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_head_value;
  logic               out_head_valid;
  logic [4:0]         out_entry_count;
  logic signed [31:0] out_removed_value;
  logic [1:0]         out_status;

  logic signed [31:0] shadow_list [QUEUE_DEPTH];
  int                 shadow_count = 0;
  logic               shadow_desc = 1'b0;
  report_t            pending_reports [$];
  script_row_t        script [SCRIPT_ROWS];

  int  error_count = 0;
  int  checked_results = 0;
  int  stall_requests = 0;
  int  stalls_done = 0;
  bit  no_wait_phase = 1'b0;
  int  insert_share [6] = '{70, 35, 55, 80, 30, 50};
  int  value_spread [6] = '{3, 1000, 2, 50, 3, 1048576};

  sorted_priority_queue #(
    .DEPTH       (QUEUE_DEPTH),
    .VALUE_WIDTH (32)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_head_value    (out_head_value),
    .out_head_valid    (out_head_valid),
    .out_entry_count   (out_entry_count),
    .out_removed_value (out_removed_value),
    .out_status        (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic report_t apply_to_shadow_list(logic cmd, logic signed [31:0] value);
    report_t r;
    int slot;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        slot = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
          if (slot == shadow_count &&
              (shadow_desc ? (shadow_list[i] < value) : (shadow_list[i] >= value))) begin
            slot = i;
          end
        end
        for (int i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[slot] = value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.removed_value = shadow_list[0];
        for (int i = 1; i < shadow_count; i++) shadow_list[i - 1] = shadow_list[i];
        shadow_count--;
      end
    end
    r.head_valid  = (shadow_count != 0);
    r.head_value  = (shadow_count != 0) ? shadow_list[0] : 32'sd0;
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  function automatic logic signed [31:0] draw_value(int spread);
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = VMAX;
      end
      1: begin
        v = VMIN;
      end
      2, 3: begin
        v = $urandom;
      end
      default: begin
        v = $signed($urandom_range(0, 2 * spread)) - spread;
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string field, logic signed [63:0] got,
                                 logic signed [63:0] want);
    error_count++;
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             field, checked_results, got, want);
  endtask

  task automatic send_word(logic cmd, logic signed [31:0] value, logic typed, report_t want);
    int gap;
    report_t predicted;
    gap = no_wait_phase ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= value;
    do @(posedge clk); while (!in_ready);
    predicted = apply_to_shadow_list(cmd, value);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  task automatic set_order(logic desc);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_desc = desc;
  endtask

  always @(posedge clk) begin : check_results
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected word", out_status, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_head_value !== want.head_value)
          report_mismatch("head_value", out_head_value, want.head_value);
        if (out_head_valid !== want.head_valid)
          report_mismatch("head_valid", out_head_valid, want.head_valid);
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", out_entry_count, want.entry_count);
        if (out_removed_value !== want.removed_value)
          report_mismatch("removed_value", out_removed_value, want.removed_value);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
      checked_results++;
    end
  end

  initial begin : receiver
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_requests != stalls_done) begin
        hold = 300;
        stalls_done++;
      end else begin
        hold = no_wait_phase ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    script[0]  = '{1'b0, spq_pkg::CMD_REMOVE, 32'sd0, 1'b1,
                   '{32'sd0, 1'b0, 5'd0, 32'sd0, spq_pkg::ST_EMPTY}};
    script[1]  = '{1'b0, spq_pkg::CMD_INSERT, VMAX, 1'b1,
                   '{VMAX, 1'b1, 5'd1, 32'sd0, spq_pkg::ST_DONE}};
    script[2]  = '{1'b0, spq_pkg::CMD_INSERT, VMIN, 1'b1,
                   '{VMIN, 1'b1, 5'd2, 32'sd0, spq_pkg::ST_DONE}};
    script[3]  = '{1'b0, spq_pkg::CMD_INSERT, 32'sd0, 1'b0, '0};
    script[4]  = '{1'b0, spq_pkg::CMD_INSERT, -32'sd1, 1'b0, '0};
    script[5]  = '{1'b0, spq_pkg::CMD_INSERT, 32'sd5, 1'b0, '0};
    script[6]  = '{1'b0, spq_pkg::CMD_INSERT, 32'sd5, 1'b0, '0};
    script[7]  = '{1'b0, spq_pkg::CMD_INSERT, 32'sd1, 1'b0, '0};
    script[8]  = '{1'b0, spq_pkg::CMD_INSERT, -32'sd7, 1'b0, '0};
    script[9]  = '{1'b0, spq_pkg::CMD_INSERT, 32'sd100, 1'b0, '0};
    script[10] = '{1'b0, spq_pkg::CMD_INSERT, 32'sd3, 1'b0, '0};
    script[11] = '{1'b0, spq_pkg::CMD_INSERT, VMIN, 1'b0, '0};
    script[12] = '{1'b0, spq_pkg::CMD_INSERT, VMAX, 1'b0, '0};
    script[13] = '{1'b0, spq_pkg::CMD_INSERT, 32'sd42, 1'b0, '0};
    script[14] = '{1'b0, spq_pkg::CMD_INSERT, -32'sd100, 1'b0, '0};
    script[15] = '{1'b0, spq_pkg::CMD_INSERT, 32'sd0, 1'b0, '0};
    script[16] = '{1'b0, spq_pkg::CMD_INSERT, 32'sd2, 1'b0, '0};
    script[17] = '{1'b0, spq_pkg::CMD_INSERT, 32'sd9, 1'b1,
                   '{VMIN, 1'b1, 5'd16, 32'sd0, spq_pkg::ST_FULL}};
    script[18] = '{1'b0, spq_pkg::CMD_REMOVE, -32'sd1, 1'b1,
                   '{VMIN, 1'b1, 5'd15, VMIN, spq_pkg::ST_DONE}};
    script[19] = '{1'b0, spq_pkg::CMD_REMOVE, 32'sd0, 1'b0, '0};
    script[20] = '{1'b0, spq_pkg::CMD_REMOVE, 32'sd0, 1'b0, '0};
    script[21] = '{1'b1, spq_pkg::CMD_INSERT, 32'sd7, 1'b0, '0};
    script[22] = '{1'b1, spq_pkg::CMD_INSERT, 32'sd7, 1'b0, '0};
    script[23] = '{1'b1, spq_pkg::CMD_INSERT, VMAX, 1'b0, '0};
    script[24] = '{1'b1, spq_pkg::CMD_REMOVE, 32'sd0, 1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].desc != shadow_desc) set_order(script[i].desc);
      send_word(script[i].cmd, script[i].value, script[i].typed, script[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      set_order((p % 2) == 1);
      no_wait_phase = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 240; n++) begin
        send_word(($urandom_range(0, 99) < insert_share[p]) ?
                    spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE,
                  draw_value(value_spread[p]), 1'b0, '0);
      end
    end

    // The receiver holds off for a long stretch while words keep coming.
    no_wait_phase = 1'b1;
    stall_requests++;
    for (int n = 0; n < 40; n++) begin
      send_word($urandom_range(0, 1) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE,
                draw_value(20), 1'b0, '0);
    end
    no_wait_phase = 1'b0;

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
